>>> src/tsrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_pkg
// Shared types and constants for the text selection region tracker.
// ----------------------------------------------------------------------------
package tsrt_pkg;

	localparam int ROW_W   = 16;
	localparam int COL_W   = 10;
	localparam int WIDTH_W = 11;
	localparam int KIND_W  = 3;

	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = WIDTH_W'(80);
	localparam logic [COL_W-1:0]   COL_MAX        = {COL_W{1'b1}};

	typedef enum logic [KIND_W-1:0] {
		KIND_BEGIN  = 3'd0,
		KIND_UPDATE = 3'd1,
		KIND_END    = 3'd2,
		KIND_LINE   = 3'd3,
		KIND_CLEAR  = 3'd4,
		KIND_QUERY  = 3'd5
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
	} item_t;

	typedef struct packed {
		logic             drag;
		logic             valid;
		logic [ROW_W-1:0] anchor_row;
		logic [COL_W-1:0] anchor_col;
		logic [ROW_W-1:0] point_row;
		logic [COL_W-1:0] point_col;
	} sel_t;

	typedef struct packed {
		logic             in_sel;
		logic             has_sel;
		logic             drag;
		logic [ROW_W-1:0] first_row;
		logic [COL_W-1:0] first_col;
		logic [ROW_W-1:0] last_row;
		logic [COL_W-1:0] last_col;
	} res_t;

endpackage

>>> src/tsrt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_step
// Next selection state and result for one registered item.
// ----------------------------------------------------------------------------
module tsrt_step (
	input  tsrt_pkg::item_t                  item,
	input  tsrt_pkg::sel_t                   sel,
	input  logic [tsrt_pkg::WIDTH_W-1:0]     line_width,
	output tsrt_pkg::sel_t                   sel_next,
	output tsrt_pkg::res_t                   res
);

	logic [tsrt_pkg::WIDTH_W-1:0] lw_m1;
	logic [tsrt_pkg::COL_W-1:0]   end_col;
	logic                         swap_pre;
	logic                         swap_post;
	logic                         row_in;
	tsrt_pkg::sel_t               ns;

	// end column of a whole-line selection, saturated to the column range
	always_comb begin
		lw_m1 = line_width - tsrt_pkg::WIDTH_W'(1);
		if (line_width == '0) begin
			end_col = '0;
		end else if (lw_m1[tsrt_pkg::WIDTH_W-1]) begin
			end_col = tsrt_pkg::COL_MAX;
		end else begin
			end_col = lw_m1[tsrt_pkg::COL_W-1:0];
		end
	end

	assign swap_pre = (sel.anchor_row > sel.point_row) ||
		(sel.anchor_row == sel.point_row && sel.anchor_col > sel.point_col);

	always_comb begin
		ns = sel;
		case (tsrt_pkg::kind_t'(item.kind))
			tsrt_pkg::KIND_BEGIN: begin
				ns.drag       = 1'b1;
				ns.valid      = 1'b1;
				ns.anchor_row = item.row;
				ns.point_row  = item.row;
				ns.anchor_col = item.column;
				ns.point_col  = item.column;
			end
			tsrt_pkg::KIND_UPDATE: begin
				if (sel.drag) begin
					ns.point_row = item.row;
					ns.point_col = item.column;
					ns.valid     = 1'b1;
				end
			end
			tsrt_pkg::KIND_END: begin
				ns.drag = 1'b0;
				if (swap_pre) begin
					ns.anchor_row = sel.point_row;
					ns.anchor_col = sel.point_col;
					ns.point_row  = sel.anchor_row;
					ns.point_col  = sel.anchor_col;
				end
				// a single-cell selection is dropped
				if (sel.anchor_row == sel.point_row && sel.anchor_col == sel.point_col) begin
					ns.valid      = 1'b0;
					ns.anchor_row = '0;
					ns.anchor_col = '0;
					ns.point_row  = '0;
					ns.point_col  = '0;
				end
			end
			tsrt_pkg::KIND_LINE: begin
				ns.drag       = 1'b0;
				ns.valid      = 1'b1;
				ns.anchor_row = item.row;
				ns.point_row  = item.row;
				ns.anchor_col = '0;
				ns.point_col  = end_col;
			end
			tsrt_pkg::KIND_CLEAR: begin
				ns.drag       = 1'b0;
				ns.valid      = 1'b0;
				ns.anchor_row = '0;
				ns.anchor_col = '0;
				ns.point_row  = '0;
				ns.point_col  = '0;
			end
			default: begin
				ns = sel;
			end
		endcase
	end

	assign sel_next = ns;

	assign swap_post = (ns.anchor_row > ns.point_row) ||
		(ns.anchor_row == ns.point_row && ns.anchor_col > ns.point_col);

	always_comb begin
		res.has_sel = ns.valid;
		res.drag    = ns.drag;
		if (!ns.valid) begin
			res.first_row = '0;
			res.first_col = '0;
			res.last_row  = '0;
			res.last_col  = '0;
		end else if (swap_post) begin
			res.first_row = ns.point_row;
			res.first_col = ns.point_col;
			res.last_row  = ns.anchor_row;
			res.last_col  = ns.anchor_col;
		end else begin
			res.first_row = ns.anchor_row;
			res.first_col = ns.anchor_col;
			res.last_row  = ns.point_row;
			res.last_col  = ns.point_col;
		end

		row_in = item.row >= res.first_row && item.row <= res.last_row;
		res.in_sel = 1'b0;
		if (item.kind == tsrt_pkg::KIND_QUERY && ns.valid && row_in) begin
			if (res.first_row == res.last_row) begin
				res.in_sel = item.column >= res.first_col && item.column <= res.last_col;
			end else if (item.row == res.first_row) begin
				res.in_sel = item.column >= res.first_col;
			end else if (item.row == res.last_row) begin
				res.in_sel = item.column <= res.last_col;
			end else begin
				res.in_sel = 1'b1;
			end
		end
	end

endmodule

>>> src/text_selection_region_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_selection_region_tracker_top
// Selection tracker on a character grid: input register, step logic,
// selection state and result register.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | kind, row, column
//  out     | out_valid / out_stall | inside_res, has_selection, dragging,
//          |                       | first_row, first_column, last_row, last_column
//  cfg     | cfg_valid / cfg_ready | cfg_data (line_width)
//
//  one item per cycle unless in_stall is high; a result passes through the
//  input register, then step logic into the result register
//  selection state updates as the item moves into the result register
//  out_stall holds the result register; in_stall rises only when the input
//  register is full and cannot move on
//  reset clears flags, points and valids and sets line_width to 80
// ----------------------------------------------------------------------------
module text_selection_region_tracker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tsrt_pkg::KIND_W-1:0]    kind,
	input  logic [tsrt_pkg::ROW_W-1:0]     row,
	input  logic [tsrt_pkg::COL_W-1:0]     column,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           inside_res,
	output logic                           has_selection,
	output logic                           dragging,
	output logic [tsrt_pkg::ROW_W-1:0]     first_row,
	output logic [tsrt_pkg::COL_W-1:0]     first_column,
	output logic [tsrt_pkg::ROW_W-1:0]     last_row,
	output logic [tsrt_pkg::COL_W-1:0]     last_column,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsrt_pkg::WIDTH_W-1:0]   cfg_data
);

	logic                         valid_s1;
	tsrt_pkg::item_t              item_s1;
	logic                         valid_s2;
	tsrt_pkg::res_t               res_s2;
	tsrt_pkg::sel_t               sel_q;
	tsrt_pkg::sel_t               sel_next;
	tsrt_pkg::res_t               res_next;
	logic [tsrt_pkg::WIDTH_W-1:0] line_width_q;
	logic                         take_in;
	logic                         advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign take_in   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= tsrt_pkg::LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			line_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.kind   <= kind;
			item_s1.row    <= row;
			item_s1.column <= column;
		end
	end

	tsrt_step u_step (
		.item       (item_s1),
		.sel        (sel_q),
		.line_width (line_width_q),
		.sel_next   (sel_next),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (advance) begin
			sel_q <= sel_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign inside_res    = res_s2.in_sel;
	assign has_selection = res_s2.has_sel;
	assign dragging      = res_s2.drag;
	assign first_row     = res_s2.first_row;
	assign first_column  = res_s2.first_col;
	assign last_row      = res_s2.last_row;
	assign last_column   = res_s2.last_col;

	// no selection means all bounds read as zero
	a_empty_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_selection) |->
		(first_row == '0 && first_column == '0 && last_row == '0 && last_column == '0))
		else $error("bounds not zero without a selection");

	a_inside_needs_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_res) |-> has_selection)
		else $error("inside reported without a selection");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_row < last_row ||
		(first_row == last_row && first_column <= last_column)))
		else $error("selection bounds out of order");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result side free");

endmodule
